// File: hdl/lcs_length_and_traceback_assert.svh
// Assertion macros shared by the LCS block.
`ifndef LCS_LENGTH_AND_TRACEBACK_ASSERT_SVH
`define LCS_LENGTH_AND_TRACEBACK_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define LCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define LCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types for the LCS length and traceback block.
// ----------------------------------------------------------------------------
package lcs_pkg;
    localparam int MAX_LEN    = 32;
    localparam int VALUE_BITS = 16;
    localparam int SIDE       = MAX_LEN + 1;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int TAB_DEPTH  = SIDE * SIDE;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int SCORE_W    = CNT_W;
    localparam int PAIR_W     = 2 * IDX_W;

    typedef struct packed {
        logic               kind;
        logic [5:0]         common_length;
        logic [4:0]         first_index;
        logic [4:0]         second_index;
        logic               end_of_run;
    } out_item_t;

    typedef struct packed {
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic        last;
    } in_item_t;

    // Datapath commands from the controller.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_FILL_RD,
        CMD_FILL_WR,
        CMD_TB_RD,
        CMD_TB_STEP,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic fill_done;
        logic tb_done;
        logic emit_last;
        logic out_free;
    } stat_t;
endpackage

// File: hdl/lcs_stream_if.sv
// ----------------------------------------------------------------------------
// lcs_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lcs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lcs_length_and_traceback.sv
// Fill: one read state and one write state per table cell, through the single
// table read port; traceback alternates a read state and a step state. A new run
// is loaded only after the last result of the previous run is in the output register.
// Reset: asynchronous active-low rst_n clears control; stores hold no reset.
// ----------------------------------------------------------------------------
// lcs_length_and_traceback
// Top level: LCS length and matched index pairs of two loaded sequences.
// ----------------------------------------------------------------------------
module lcs_length_and_traceback (
    input  logic         clk,
    input  logic         rst_n,
    lcs_stream_if.sink   in_ch,
    lcs_stream_if.source out_ch
);
    import lcs_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    lcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.data.last), .in_ready(in_ch.ready),
        .ctrl(ctrl), .stat(stat)
    );

    lcs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .in_item(in_ch.data), .out_item(out_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready)
    );
endmodule

// File: hdl/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/lcs_datapath.sv
// ----------------------------------------------------------------------------
// lcs_datapath
// Element stores, score table walk, traceback and result register.
// ----------------------------------------------------------------------------
module lcs_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  lcs_pkg::ctrl_t    ctrl,
    output lcs_pkg::stat_t    stat,
    input  lcs_pkg::in_item_t in_item,
    output lcs_pkg::out_item_t out_item,
    output logic              out_valid,
    input  logic              out_ready
);
    import lcs_pkg::*;

    // Element stores are small enough to keep in registers.
    logic [VALUE_BITS-1:0] a_reg [MAX_LEN];
    logic [VALUE_BITS-1:0] b_reg [MAX_LEN];
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      i_reg, j_reg;
    logic [SCORE_W-1:0]    left_reg, diag_reg;
    logic [SCORE_W-1:0]    len_reg;
    logic [CNT_W-1:0]      cnt_reg, emit_reg;
    logic [PAIR_W-1:0]     pairs_reg [MAX_LEN];
    out_item_t             out_reg;
    logic                  ov_reg;

    // Score table memory: up value read for (i-1,j), written at (i,j).
    logic                  t_we;
    logic [TAB_AW-1:0]     t_waddr, t_raddr;
    logic [SCORE_W-1:0]    t_wdata, t_rdata;

    lcs_ram #(.WIDTH(SCORE_W), .DEPTH(TAB_DEPTH)) u_tab (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    function automatic logic [TAB_AW-1:0] addr(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
        addr = TAB_AW'(r * SIDE + c);
    endfunction

    logic               match;
    logic [SCORE_W-1:0] up, cell_score;
    logic [SCORE_W-1:0] cur_reg;

    assign match = (a_reg[i_reg[IDX_W-1:0] - 1'b1] == b_reg[j_reg[IDX_W-1:0] - 1'b1]);
    // Row zero is never written: first row reads as zero.
    assign up    = (i_reg == CNT_W'(1)) ? '0 : t_rdata;
    assign cell_score = match ? SCORE_W'(diag_reg + 1'b1) :
                        ((up > left_reg) ? up : left_reg);

    always_comb
    begin
        t_we    = (ctrl.op == CMD_FILL_WR);
        t_waddr = addr(i_reg, j_reg);
        t_wdata = cell_score;
        unique case (ctrl.op)
            CMD_TB_RD: t_raddr = addr(CNT_W'(i_reg - 1'b1), j_reg);
            default:   t_raddr = addr(CNT_W'(i_reg - 1'b1), j_reg);
        endcase
    end

    assign stat.fill_done = (i_reg == n_reg) && (j_reg == n_reg);
    assign stat.tb_done   = (i_reg == '0) || (j_reg == '0);
    assign stat.emit_last = (emit_reg == '0);
    assign stat.out_free  = !ov_reg || out_ready;

    assign out_item  = out_reg;
    assign out_valid = ov_reg;

    // Element store and traceback pair writes.
    always_ff @(posedge clk)
    begin
        if (ctrl.op == CMD_LOAD && n_reg < CNT_W'(MAX_LEN))
        begin
            a_reg[n_reg[IDX_W-1:0]] <= in_item.first_value[VALUE_BITS-1:0];
            b_reg[n_reg[IDX_W-1:0]] <= in_item.second_value[VALUE_BITS-1:0];
        end
        if (ctrl.op == CMD_TB_STEP && match)
        begin
            pairs_reg[cnt_reg[IDX_W-1:0]] <= {IDX_W'(i_reg - 1'b1), IDX_W'(j_reg - 1'b1)};
        end
    end

    // Walk counters and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            left_reg <= '0;
            diag_reg <= '0;
            cur_reg  <= '0;
            len_reg  <= '0;
            cnt_reg  <= '0;
            emit_reg <= '0;
            ov_reg   <= 1'b0;
            out_reg  <= '0;
        end
        else
        begin
            // Result taken and nothing new loaded this cycle
            if (ov_reg && out_ready && ctrl.op != CMD_EMIT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (ctrl.op)
                CMD_LOAD:
                begin
                    if (n_reg < CNT_W'(MAX_LEN))
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                    if (in_item.last)
                    begin
                        i_reg    <= CNT_W'(1);
                        j_reg    <= CNT_W'(1);
                        left_reg <= '0;
                        diag_reg <= '0;
                    end
                end
                CMD_FILL_WR:
                begin
                    if (j_reg == n_reg)
                    begin
                        if (i_reg == n_reg)
                        begin
                            len_reg <= cell_score;
                            cur_reg <= cell_score;
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= CNT_W'(1);
                        end
                        left_reg <= '0;
                        diag_reg <= '0;
                    end
                    else
                    begin
                        j_reg    <= j_reg + 1'b1;
                        left_reg <= cell_score;
                        diag_reg <= up;
                    end
                end
                CMD_TB_STEP:
                begin
                    if (match)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        i_reg   <= i_reg - 1'b1;
                        j_reg   <= j_reg - 1'b1;
                        cur_reg <= cur_reg - 1'b1;
                    end
                    else if (up == cur_reg)
                    begin
                        i_reg <= i_reg - 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg - 1'b1;
                    end
                end
                CMD_EMIT:
                begin
                    ov_reg <= 1'b1;
                    out_reg.common_length <= 6'(len_reg);
                    if (emit_reg == '0)
                    begin
                        out_reg.kind         <= 1'b0;
                        out_reg.first_index  <= '0;
                        out_reg.second_index <= '0;
                        out_reg.end_of_run   <= (cnt_reg == '0);
                        emit_reg             <= cnt_reg;
                    end
                    else
                    begin
                        out_reg.kind         <= 1'b1;
                        out_reg.first_index  <= 5'(pairs_reg[emit_reg[IDX_W-1:0] - 1'b1]
                                                   [PAIR_W-1:IDX_W]);
                        out_reg.second_index <= 5'(pairs_reg[emit_reg[IDX_W-1:0] - 1'b1]
                                                   [IDX_W-1:0]);
                        out_reg.end_of_run   <= (emit_reg == CNT_W'(1));
                        emit_reg             <= emit_reg - 1'b1;
                        if (emit_reg == CNT_W'(1))
                        begin
                            n_reg <= '0;
                        end
                    end
                    if (cnt_reg == '0)
                    begin
                        n_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// File: hdl/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: load, table fill, traceback and emission.
// ----------------------------------------------------------------------------
`include "lcs_length_and_traceback_assert.svh"
module lcs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output lcs_pkg::ctrl_t ctrl,
    input  lcs_pkg::stat_t stat
);
    import lcs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_FRD, S_FWR, S_TRD, S_TSTEP, S_HDR, S_PAIRS
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = CMD_IDLE;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    ctrl.op = CMD_LOAD;
                    if (in_last)
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                ctrl.op    = CMD_FILL_RD;
                state_next = S_FWR;
            end
            S_FWR:
            begin
                ctrl.op    = CMD_FILL_WR;
                state_next = stat.fill_done ? S_TRD : S_FRD;
            end
            S_TRD:
            begin
                ctrl.op    = CMD_TB_RD;
                state_next = stat.tb_done ? S_HDR : S_TSTEP;
            end
            S_TSTEP:
            begin
                ctrl.op    = CMD_TB_STEP;
                state_next = S_TRD;
            end
            S_HDR:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = CMD_EMIT;
                    state_next = S_PAIRS;
                end
            end
            S_PAIRS:
            begin
                if (stat.out_free)
                begin
                    if (stat.emit_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        ctrl.op = CMD_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `LCS_ASSERT_IMP(a_ready_only_load, in_ready, state_reg == S_LOAD)
    `LCS_ASSERT_NXT(a_last_starts_fill, in_valid && in_ready && in_last, state_reg == S_FRD)
    `LCS_ASSERT_NXT(a_fill_alternates, state_reg == S_FRD, state_reg == S_FWR)
endmodule

// File: test/lcs_length_and_traceback_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_and_traceback_tb
// Self-checking bench: loads random and directed sequence pairs, predicts the
// LCS header and traceback pairs, and checks every output transaction.
// ----------------------------------------------------------------------------
module lcs_length_and_traceback_tb;
    import lcs_pkg::*;

    localparam int LIMIT       = 3000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk;
    logic rst_n;

    lcs_stream_if #(.payload_t(in_item_t))  in_ch ();
    lcs_stream_if #(.payload_t(out_item_t)) out_ch ();

    lcs_length_and_traceback uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Predictor state
    logic [15:0] seq_a [MAX_LEN];
    logic [15:0] seq_b [MAX_LEN];
    int          fill_count;
    out_item_t   expected_q [$];
    in_item_t    pending_q [$];

    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    logic hold_off;
    logic in_taken;
    int   errors;
    int   cycles;

    // Fold one accepted transaction into the LCS predictor.
    task automatic predict_lcs(input in_item_t it);
        int        n;
        int        i;
        int        j;
        int        cnt;
        int        k;
        logic [5:0] score [SIDE][SIDE];
        logic [4:0] pa [MAX_LEN];
        logic [4:0] pb [MAX_LEN];
        out_item_t  r;
        if (fill_count < MAX_LEN)
        begin
            seq_a[fill_count] = it.first_value;
            seq_b[fill_count] = it.second_value;
            fill_count++;
        end
        if (!it.last)
            return;
        n = fill_count;
        for (i = 0; i <= n; i++)
        begin
            score[i][0] = '0;
            score[0][i] = '0;
        end
        for (i = 1; i <= n; i++)
            for (j = 1; j <= n; j++)
                if (seq_a[i-1] == seq_b[j-1])
                    score[i][j] = score[i-1][j-1] + 6'd1;
                else
                    score[i][j] = (score[i-1][j] > score[i][j-1]) ?
                                  score[i-1][j] : score[i][j-1];
        cnt = 0;
        i = n;
        j = n;
        while (i > 0 && j > 0)
        begin
            if (seq_a[i-1] == seq_b[j-1])
            begin
                pa[cnt] = 5'(i - 1);
                pb[cnt] = 5'(j - 1);
                cnt++;
                i--;
                j--;
            end
            else if (score[i-1][j] == score[i][j])
                i--;
            else
                j--;
        end
        r = '0;
        r.common_length = score[n][n];
        r.end_of_run = (cnt == 0);
        expected_q.push_back(r);
        for (k = 0; k < cnt; k++)
        begin
            r.kind = 1'b1;
            r.first_index = pa[cnt-1-k];
            r.second_index = pb[cnt-1-k];
            r.end_of_run = (k + 1 == cnt);
            expected_q.push_back(r);
        end
        fill_count = 0;
    endtask

    task automatic report(input string what, input out_item_t got, input out_item_t exp);
        errors++;
        $display("mismatch %s: got %p expected %p", what, got, exp);
    endtask

    // Input acceptance seen at the last rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
    end

    // Driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else if (in_ch.valid && !in_taken)
            ;
        else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            in_ch.data <= pending_q.pop_front();
            in_ch.valid <= 1'b1;
        end
        else
            in_ch.valid <= 1'b0;
    end

    // Long receiver hold-off, counted in its own process
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Receiver stall
    always @(negedge clk)
    begin
        if (hold_off)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sample on the rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_lcs(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected transaction", out_ch.data, '0);
            else
            begin
                out_item_t e;
                e = expected_q.pop_front();
                if (out_ch.data.kind != e.kind)
                    report("kind", out_ch.data, e);
                else if (out_ch.data.common_length != e.common_length)
                    report("common_length", out_ch.data, e);
                else if (out_ch.data.first_index != e.first_index)
                    report("first_index", out_ch.data, e);
                else if (out_ch.data.second_index != e.second_index)
                    report("second_index", out_ch.data, e);
                else if (out_ch.data.end_of_run != e.end_of_run)
                    report("end_of_run", out_ch.data, e);
            end
        end
        if (cycles > LIMIT)
        begin
            $display("[lcs_length_and_traceback] ERROR");
            $finish;
        end
    end

    // Queue one sequence pair of length len; alphabet bounds match density.
    task automatic queue_load(input int len, input int alpha);
        in_item_t it;
        int       k;
        for (k = 0; k < len; k++)
        begin
            if (alpha == 0)
            begin
                it.first_value = 16'($urandom);
                it.second_value = 16'($urandom);
            end
            else
            begin
                it.first_value = 16'($urandom_range(alpha - 1)) ^ 16'h8000;
                it.second_value = 16'($urandom_range(alpha - 1)) ^ 16'h8000;
            end
            it.last = (k == len - 1);
            pending_q.push_back(it);
        end
    endtask

    task automatic queue_fixed(input logic [15:0] a, input logic [15:0] b, input logic l);
        in_item_t it;
        it.first_value = a;
        it.second_value = b;
        it.last = l;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int k;
        rst_n = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: single pairs, equal and unequal, then short runs; extremes of the values
        queue_fixed(16'h8000, 16'h8000, 1'b1);
        queue_fixed(16'h7FFF, 16'h8000, 1'b1);
        queue_fixed(16'hFFFF, 16'h0000, 1'b0);
        queue_fixed(16'h0000, 16'hFFFF, 1'b1);
        queue_fixed(16'h5555, 16'hAAAA, 1'b0);
        queue_fixed(16'hAAAA, 16'h5555, 1'b0);
        queue_fixed(16'h1234, 16'h1234, 1'b1);
        // Overlong load: 40 items, extra ones ignored, all equal
        for (k = 0; k < 40; k++)
            queue_fixed(16'h0007, 16'h0007, k == 39);
        drain();

        // Random loads through the idling phases
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? 71 : 0;
            recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 17 : 0;
            if (ph == 3)
                send_idle_pct = 17;
            if (ph == 0)
                hold_req = 1'b1;
            for (k = 0; k < 10; k++)
                queue_load((k == 9) ? 32 : $urandom_range(1, 8),
                           (k % 3 == 0) ? 0 : $urandom_range(2, 4));
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[lcs_length_and_traceback] OK");
        else
            $display("[lcs_length_and_traceback] ERROR");
        $finish;
    end
endmodule

// File: lcs_length_and_traceback.f
+incdir+hdl
hdl/lcs_pkg.sv
hdl/lcs_stream_if.sv
hdl/lcs_ram.sv
hdl/lcs_datapath.sv
hdl/lcs_ctrl.sv
hdl/lcs_length_and_traceback.sv
test/lcs_length_and_traceback_tb.sv
